/* sv/chunked_body_decoder_macros.svh */
// Assertion macros for the chunked body decoder RTL.
`ifndef CHUNKED_BODY_DECODER_MACROS_SVH
`define CHUNKED_BODY_DECODER_MACROS_SVH

// Condition holds at every edge outside reset.
`define CBD_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("cbd assertion failed");

// Antecedent at an edge implies consequent at the same edge.
`define CBD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbd implication failed");

// Antecedent at an edge implies consequent at the next edge.
`define CBD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbd next-cycle check failed");

`endif

/* sv/cbd_pkg.sv */
// Types, codes and helpers for the chunked body decoder.
`timescale 1ns / 1ps
`default_nettype none
package cbd_pkg;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  localparam logic [2:0] PH_SIZE    = 3'd0;
  localparam logic [2:0] PH_SIZE_LF = 3'd1;
  localparam logic [2:0] PH_DATA    = 3'd2;
  localparam logic [2:0] PH_DATA_CR = 3'd3;
  localparam logic [2:0] PH_DATA_LF = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_CHAR  = 3'd1;
  localparam logic [2:0] ERR_EMPTY = 3'd2;
  localparam logic [2:0] ERR_OVF   = 3'd3;
  localparam logic [2:0] ERR_CRLF  = 3'd4;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       body_end;
    logic [2:0] error_code;
  } out_item_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       digit_seen;
    logic [2:0] err;
  } cbd_ctrl_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/cbd_step.sv */
// Per-byte next-state and result logic of the chunked body decoder.
`timescale 1ns / 1ps
`default_nettype none
module cbd_step import cbd_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  in_item_t               item,
  input  cbd_ctrl_t              ctrl,
  input  logic [SIZE_BITS-1:0]   count,
  output cbd_ctrl_t              ctrl_next,
  output logic [SIZE_BITS-1:0]   count_next,
  output out_item_t              result
);

  logic [4:0]           hx;
  logic [SIZE_BITS-1:0] count_dec;
  logic [7:0]           pay;
  logic                 pay_valid;

  assign hx        = hex_digit(item.data_byte);
  assign count_dec = count - {{(SIZE_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    ctrl_next  = ctrl;
    count_next = count;
    pay        = 8'd0;
    pay_valid  = 1'b0;
    if (item.kind == KIND_RESTART) begin
      ctrl_next.phase      = PH_SIZE;
      ctrl_next.digit_seen = 1'b0;
      ctrl_next.err        = ERR_NONE;
      count_next           = '0;
    end else if (ctrl.err == ERR_NONE) begin
      case (ctrl.phase)
        PH_SIZE: begin
          if (item.data_byte == CH_CR) begin
            if (ctrl.digit_seen) ctrl_next.phase = PH_SIZE_LF;
            else ctrl_next.err = ERR_EMPTY;
          end else if (!hx[4]) begin
            ctrl_next.err = ERR_CHAR;
          end else if (count[SIZE_BITS-1 -: 4] != 4'd0) begin
            ctrl_next.err = ERR_OVF;
          end else begin
            count_next           = {count[SIZE_BITS-5:0], hx[3:0]};
            ctrl_next.digit_seen = 1'b1;
          end
        end
        PH_SIZE_LF: begin
          if (item.data_byte != CH_LF) begin
            ctrl_next.err = ERR_CHAR;
          end else begin
            ctrl_next.digit_seen = 1'b0;
            ctrl_next.phase      = (count == '0) ? PH_DONE : PH_DATA;
          end
        end
        PH_DATA: begin
          pay        = item.data_byte;
          pay_valid  = 1'b1;
          count_next = count_dec;
          if (count_dec == '0) ctrl_next.phase = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (item.data_byte == CH_CR) ctrl_next.phase = PH_DATA_LF;
          else ctrl_next.err = ERR_CRLF;
        end
        PH_DATA_LF: begin
          if (item.data_byte == CH_LF) begin
            ctrl_next.phase      = PH_SIZE;
            ctrl_next.digit_seen = 1'b0;
            count_next           = '0;
          end else begin
            ctrl_next.err = ERR_CRLF;
          end
        end
        default: begin
          // ended (and unreachable codes): bytes ignored
        end
      endcase
    end
  end

  always_comb begin
    result.payload_byte  = pay;
    result.payload_valid = pay_valid;
    result.body_end      = (ctrl_next.err == ERR_NONE) && (ctrl_next.phase >= PH_DONE);
    result.error_code    = ctrl_next.err;
  end

endmodule
`default_nettype wire

/* sv/chunked_body_decoder.sv */
// Chunked transfer body decoder: input register, step logic, result register.
// A request is taken into the input register; its result and the decoder state
//   are registered once the result register is free, and dec offers the result.
// Throughput: one request per cycle while dec is not stalled.
// Reset: rst (synchronous) empties both registers and returns the decoder
//   to reading a size line with no error; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "chunked_body_decoder_macros.svh"
module chunked_body_decoder import cbd_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      body_valid,
  output logic      body_ready,
  input  in_item_t  body,
  output logic      dec_valid,
  input  logic      dec_ready,
  output out_item_t dec
);

  logic                 s1_valid;
  in_item_t             s1_item;
  cbd_ctrl_t            ctrl;
  logic [SIZE_BITS-1:0] count;
  cbd_ctrl_t            ctrl_next;
  logic [SIZE_BITS-1:0] count_next;
  out_item_t            step_result;
  logic                 advance;
  logic                 step_fire;

  assign advance    = !dec_valid || dec_ready;
  assign step_fire  = s1_valid && advance;
  assign body_ready = !s1_valid || advance;

  cbd_step #(.SIZE_BITS(SIZE_BITS)) u_step (
    .item       (s1_item),
    .ctrl       (ctrl),
    .count      (count),
    .ctrl_next  (ctrl_next),
    .count_next (count_next),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (body_ready) begin
      s1_valid <= body_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (body_ready && body_valid) begin
      s1_item <= body;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.phase      <= PH_SIZE;
      ctrl.digit_seen <= 1'b0;
      ctrl.err        <= ERR_NONE;
      count           <= '0;
    end else if (step_fire) begin
      ctrl  <= ctrl_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (advance) begin
      dec_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      dec <= step_result;
    end
  end

  `CBD_ASSERT_IMP(a_no_pay_at_end, dec_valid, !(dec.payload_valid && dec.body_end))
  `CBD_ASSERT_IMP(a_err_quiet, dec_valid && dec.error_code != ERR_NONE,
                  !dec.payload_valid && !dec.body_end)
  `CBD_ASSERT_IMP(a_data_count, ctrl.phase == PH_DATA, count != '0)
  `CBD_ASSERT_NXT(a_err_sticky,
                  ctrl.err != ERR_NONE && !(step_fire && s1_item.kind == KIND_RESTART),
                  ctrl.err == $past(ctrl.err))
  `CBD_ASSERT(a_err_range, ctrl.err <= ERR_CRLF)

endmodule
`default_nettype wire

/* sim/tb_chunked_body_decoder.sv */
// Self-checking testbench for chunked_body_decoder: directed table, then random bodies.
`timescale 1ns / 1ps
module tb_chunked_body_decoder;
  import cbd_pkg::*;

  localparam int SIZE_BITS = 32;
  localparam int N_RANDOM  = 1350;
  localparam int N_DIR     = 28;
  localparam int HOLD_AT   = 300;
  localparam int HOLD_LEN  = 250;

  typedef struct packed {
    in_item_t  req;
    logic      typed;  // want holds a hand-written result
    out_item_t want;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      body_valid = 1'b0;
  logic      body_ready;
  in_item_t  body = '0;
  logic      dec_valid;
  logic      dec_ready = 1'b0;
  out_item_t dec;

  chunked_body_decoder #(.SIZE_BITS(SIZE_BITS)) uut (
    .clk       (clk),
    .rst       (rst),
    .body_valid(body_valid),
    .body_ready(body_ready),
    .body      (body),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // decoder state as predicted
  logic [2:0]           ph = PH_SIZE;
  logic [SIZE_BITS-1:0] size_left = '0;
  logic                 digit_seen = 1'b0;
  logic [2:0]           err_hold = ERR_NONE;

  stim_t      body_q[$];
  logic [7:0] body_bytes[$];
  out_item_t  decoded_q[$];
  stim_t      dir_tab [N_DIR];
  stim_t      cur_row;

  int fails = 0;
  int n_reqs = 0;
  int n_results = 0;
  int n_payload = 0;
  int n_ended = 0;
  int err_seen [5];
  int burst_left = 0;
  int gap_left = 0;
  int rx_left = 0;
  int rx_mode = 0;
  int rx_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  function automatic int hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  function automatic out_item_t decode_byte(input in_item_t r);
    out_item_t res;
    int        hv;
    res = '0;
    if (r.kind == KIND_RESTART) begin
      ph = PH_SIZE;
      size_left = '0;
      digit_seen = 1'b0;
      err_hold = ERR_NONE;
    end else if (err_hold == ERR_NONE) begin
      case (ph)
        PH_SIZE: begin
          hv = hex_val(r.data_byte);
          if (r.data_byte == CH_CR) begin
            if (digit_seen) ph = PH_SIZE_LF;
            else err_hold = ERR_EMPTY;
          end else if (hv < 0) begin
            err_hold = ERR_CHAR;
          end else if ((size_left >> (SIZE_BITS - 4)) != 0) begin
            err_hold = ERR_OVF;
          end else begin
            size_left = {size_left[SIZE_BITS-5:0], 4'(hv)};
            digit_seen = 1'b1;
          end
        end
        PH_SIZE_LF: begin
          if (r.data_byte != CH_LF) begin
            err_hold = ERR_CHAR;
          end else begin
            digit_seen = 1'b0;
            ph = (size_left == 0) ? PH_DONE : PH_DATA;
          end
        end
        PH_DATA: begin
          res.payload_byte = r.data_byte;
          res.payload_valid = 1'b1;
          size_left = size_left - 1'b1;
          if (size_left == 0) ph = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (r.data_byte == CH_CR) ph = PH_DATA_LF;
          else err_hold = ERR_CRLF;
        end
        PH_DATA_LF: begin
          if (r.data_byte == CH_LF) begin
            ph = PH_SIZE;
            size_left = '0;
            digit_seen = 1'b0;
          end else begin
            err_hold = ERR_CRLF;
          end
        end
        default: ;
      endcase
    end
    res.body_end = (err_hold == ERR_NONE && ph >= PH_DONE);
    res.error_code = err_hold;
    return res;
  endfunction

  function automatic stim_t known_row(input logic k, input logic [7:0] b,
                                      input logic [7:0] pb, input logic pv,
                                      input logic be, input logic [2:0] ec);
    stim_t s;
    s.req = '{kind: k, data_byte: b};
    s.typed = 1'b1;
    s.want = '{payload_byte: pb, payload_valid: pv, body_end: be, error_code: ec};
    return s;
  endfunction

  function automatic stim_t open_row(input logic k, input logic [7:0] b);
    stim_t s;
    s = '0;
    s.req = '{kind: k, data_byte: b};
    return s;
  endfunction

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'(8'h30 + v);
    return 8'((($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  // a byte likely to hit a phase edge: CR, LF, a digit or anything
  function automatic logic [7:0] odd_byte();
    case ($urandom_range(0, 3))
      0: return CH_CR;
      1: return CH_LF;
      2: return hex_char($urandom_range(0, 15));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic put_size(input int sz);
    int nd;
    nd = 1;
    while (nd < 8 && (sz >> (4 * nd)) != 0) nd++;
    repeat ($urandom_range(0, 2)) body_bytes.push_back(8'h30);
    for (int i = nd - 1; i >= 0; i--) body_bytes.push_back(hex_char((sz >> (4 * i)) & 15));
    body_bytes.push_back(CH_CR);
    body_bytes.push_back(CH_LF);
  endtask

  task automatic make_body();
    int roll;
    int sz;
    int pos;
    body_bytes.delete();
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 12)) body_bytes.push_back(8'($urandom));
    end else if (roll < 14) begin
      // more significant digits than the size field holds
      body_bytes.push_back(hex_char($urandom_range(1, 15)));
      repeat ($urandom_range(8, 10)) body_bytes.push_back(hex_char($urandom_range(0, 15)));
      repeat ($urandom_range(0, 3)) body_bytes.push_back(8'($urandom));
    end else if (roll < 18) begin
      // full-width size, cut short by the next restart
      body_bytes.push_back(hex_char($urandom_range(1, 15)));
      repeat (7) body_bytes.push_back(hex_char($urandom_range(0, 15)));
      body_bytes.push_back(CH_CR);
      body_bytes.push_back(CH_LF);
      repeat ($urandom_range(1, 5)) body_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        sz = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 16) : $urandom_range(17, 64);
        put_size(sz);
        body_bytes.pop_back();
        body_bytes.pop_back();
        body_bytes.push_back(CH_CR);
        body_bytes.push_back(CH_LF);
        repeat (sz) body_bytes.push_back(8'($urandom));
        body_bytes.push_back(CH_CR);
        body_bytes.push_back(CH_LF);
      end
      put_size(0);
      repeat ($urandom_range(0, 3)) body_bytes.push_back(8'($urandom));
      if (roll < 45) begin
        pos = $urandom_range(0, body_bytes.size() - 1);
        case ($urandom_range(0, 3))
          0: body_bytes[pos] = odd_byte();
          1: body_bytes.insert(pos, odd_byte());
          2: body_bytes.delete(pos);
          default: body_bytes = body_bytes[0:pos];
        endcase
      end
    end
    body_q.push_back(open_row(KIND_RESTART, 8'($urandom)));
    foreach (body_bytes[k]) body_q.push_back(open_row(KIND_BYTE, body_bytes[k]));
  endtask

  // sender: bursts of requests with random gaps
  always @(posedge clk) begin
    if (rst) begin
      body_valid <= 1'b0;
    end else begin
      if (body_valid && body_ready) begin
        out_item_t pred;
        pred = decode_byte(cur_row.req);
        decoded_q.push_back(cur_row.typed ? cur_row.want : pred);
        n_reqs++;
      end
      if (!body_valid || body_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          body_valid <= 1'b0;
        end else if (body_q.size() != 0) begin
          cur_row = body_q.pop_front();
          body <= cur_row.req;
          body_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          body_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: own stall pattern, plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (rst) begin
      dec_ready <= 1'b0;
    end else begin
      if (dec_valid && dec_ready) rx_seen++;
      if (hold_left > 0) begin
        hold_left--;
        dec_ready <= 1'b0;
      end else if (!hold_done && rx_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        dec_ready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 9);
          rx_left = (rx_mode >= 8) ? $urandom_range(1, 6) : $urandom_range(1, 40);
        end
        rx_left--;
        if (rx_mode < 4) dec_ready <= 1'b1;
        else if (rx_mode < 8) dec_ready <= ($urandom_range(0, 2) != 0);
        else dec_ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && dec_valid && dec_ready) begin
      n_results++;
      if (decoded_q.size() == 0) begin
        fails++;
        if (fails <= 25) $display("%0t: result with nothing expected, got %h", $time, dec);
      end else begin
        want = decoded_q.pop_front();
        if (dec !== want) begin
          fails++;
          if (fails <= 25) begin
            if (dec.payload_byte !== want.payload_byte)
              $display("%0t: payload_byte expected %02h got %02h",
                       $time, want.payload_byte, dec.payload_byte);
            if (dec.payload_valid !== want.payload_valid)
              $display("%0t: payload_valid expected %b got %b",
                       $time, want.payload_valid, dec.payload_valid);
            if (dec.body_end !== want.body_end)
              $display("%0t: body_end expected %b got %b", $time, want.body_end, dec.body_end);
            if (dec.error_code !== want.error_code)
              $display("%0t: error_code expected %0d got %0d",
                       $time, want.error_code, dec.error_code);
          end
        end
        if (want.payload_valid) n_payload++;
        if (want.body_end) n_ended++;
        if (want.error_code <= ERR_CRLF) err_seen[want.error_code]++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d requests sent, %0d results still pending", n_reqs, decoded_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    foreach (err_seen[i]) err_seen[i] = 0;
    dir_tab = '{
      known_row(KIND_RESTART, 8'hA5, 8'h00, 1'b0, 1'b0, ERR_NONE),
      known_row(KIND_BYTE,    CH_CR, 8'h00, 1'b0, 1'b0, ERR_EMPTY),
      known_row(KIND_BYTE,    8'h31, 8'h00, 1'b0, 1'b0, ERR_EMPTY),  // sticky
      known_row(KIND_RESTART, 8'hFF, 8'h00, 1'b0, 1'b0, ERR_NONE),
      known_row(KIND_BYTE,    8'h67, 8'h00, 1'b0, 1'b0, ERR_CHAR),
      known_row(KIND_RESTART, 8'h00, 8'h00, 1'b0, 1'b0, ERR_NONE),
      open_row(KIND_BYTE, 8'h30),
      open_row(KIND_BYTE, CH_CR),
      known_row(KIND_BYTE,    CH_LF, 8'h00, 1'b0, 1'b1, ERR_NONE),
      known_row(KIND_BYTE,    8'hFF, 8'h00, 1'b0, 1'b1, ERR_NONE),  // ignored past end
      known_row(KIND_RESTART, 8'h00, 8'h00, 1'b0, 1'b0, ERR_NONE),
      open_row(KIND_BYTE, 8'h30),
      open_row(KIND_BYTE, 8'h32),
      open_row(KIND_BYTE, CH_CR),
      open_row(KIND_BYTE, CH_LF),
      known_row(KIND_BYTE,    8'h00, 8'h00, 1'b1, 1'b0, ERR_NONE),
      known_row(KIND_BYTE,    8'hFF, 8'hFF, 1'b1, 1'b0, ERR_NONE),
      known_row(KIND_BYTE,    8'h5A, 8'h00, 1'b0, 1'b0, ERR_CRLF),
      known_row(KIND_RESTART, 8'h5A, 8'h00, 1'b0, 1'b0, ERR_NONE),
      open_row(KIND_BYTE, 8'h46),
      open_row(KIND_BYTE, 8'h66),
      open_row(KIND_BYTE, 8'h41),
      open_row(KIND_BYTE, 8'h61),
      open_row(KIND_BYTE, 8'h39),
      open_row(KIND_BYTE, 8'h30),
      open_row(KIND_BYTE, 8'h38),
      open_row(KIND_BYTE, 8'h31),
      known_row(KIND_BYTE,    8'h46, 8'h00, 1'b0, 1'b0, ERR_OVF)
    };
    foreach (dir_tab[i]) body_q.push_back(dir_tab[i]);
    while (body_q.size() < N_DIR + N_RANDOM) make_body();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (body_q.size() != 0 || body_valid) @(negedge clk);
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);

    $display("covered %0d requests, %0d payload bytes, %0d results past a body end",
             n_reqs, n_payload, n_ended);
    $display("errors: bad char %0d, empty size %0d, overflow %0d, missing crlf %0d",
             err_seen[ERR_CHAR], err_seen[ERR_EMPTY], err_seen[ERR_OVF], err_seen[ERR_CRLF]);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
